// ----- rtl/cri_pkg.sv -----
// Shared types and constants of the color ramp interpolator.
// Holds the opcodes, the controller-to-datapath command group and the reset ramp colors.
// No dependencies.
package cri_pkg;

   localparam int MAX_COLORS_DEF    = 16;
   localparam int FRACTION_BITS_DEF = 16;

   localparam int POS_W   = 18;   // signed Q2.16 scalar
   localparam int POS_FW  = 16;   // fraction bits of the scalar
   localparam int CHAN_W  = 8;
   localparam int ENTRY_W = 4 * CHAN_W;
   localparam int OP_W    = 2;

   localparam logic [OP_W-1:0] OP_SAMPLE = 2'd0;
   localparam logic [OP_W-1:0] OP_APPEND = 2'd1;
   localparam logic [OP_W-1:0] OP_CLEAR  = 2'd2;

   // number of ramp entries loaded at reset
   localparam int RESET_ENTRIES = 3;

   // entries pack red 7..0, green 15..8, blue 23..16, alpha 31..24
   localparam logic [ENTRY_W-1:0] COLOR_RED   = 32'hFF00_00FF;
   localparam logic [ENTRY_W-1:0] COLOR_WHITE = 32'hFFFF_FFFF;
   localparam logic [ENTRY_W-1:0] COLOR_BLUE  = 32'hFFFF_0000;

   typedef struct packed {
      logic accept;   // input transfer this cycle
      logic read;     // read the two ramp entries
      logic load;     // load the result register
   } cmd_type;

   function automatic logic [ENTRY_W-1:0] reset_color(input logic [1:0] sel);
      logic [ENTRY_W-1:0] c;
      case (sel)
         2'd0:    c = COLOR_RED;
         2'd1:    c = COLOR_WHITE;
         2'd2:    c = COLOR_BLUE;
         default: c = '0;
      endcase
      return c;
   endfunction

endpackage

// ----- rtl/cri_ctrl.sv -----
// Controller of the color ramp interpolator: sequences accept, table read and result load.
// Owns the result valid flag. Depends on cri_pkg.
module cri_ctrl (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output cri_pkg::cmd_type cmd
);

   localparam logic [1:0] S_IDLE = 2'd0;
   localparam logic [1:0] S_READ = 2'd1;
   localparam logic [1:0] S_LERP = 2'd2;

   logic [1:0] state_ff, state_in;
   logic       rsp_valid_ff, rsp_valid_in;
   logic       out_free;

   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      state_in   = state_ff;
      cmd.accept = 1'b0;
      cmd.read   = 1'b0;
      cmd.load   = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.accept = 1'b1;
               state_in   = S_READ;
            end
         end
         S_READ: begin
            cmd.read = 1'b1;
            state_in = S_LERP;
         end
         S_LERP: begin
            // hold until the result register is free
            if (out_free) begin
               cmd.load = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_comb begin
      if (cmd.load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

// ----- rtl/cri_datapath.sv -----
// Datapath of the color ramp interpolator: ramp table memory, entry count,
// scale multiply, four-lane lerp and result register. Depends on cri_pkg.
module cri_datapath #(
   parameter int MAX_COLORS    = cri_pkg::MAX_COLORS_DEF,
   parameter int FRACTION_BITS = cri_pkg::FRACTION_BITS_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   input  cri_pkg::cmd_type                    cmd,
   input  logic [cri_pkg::OP_W-1:0]            req_opcode,
   input  logic signed [cri_pkg::POS_W-1:0]    req_position,
   input  logic [cri_pkg::CHAN_W-1:0]          req_red_in,
   input  logic [cri_pkg::CHAN_W-1:0]          req_green_in,
   input  logic [cri_pkg::CHAN_W-1:0]          req_blue_in,
   input  logic [cri_pkg::CHAN_W-1:0]          req_alpha_in,
   output logic [cri_pkg::CHAN_W-1:0]          rsp_red_out,
   output logic [cri_pkg::CHAN_W-1:0]          rsp_green_out,
   output logic [cri_pkg::CHAN_W-1:0]          rsp_blue_out,
   output logic [cri_pkg::CHAN_W-1:0]          rsp_alpha_out,
   output logic                                rsp_status
);

   localparam int IDXW  = $clog2(MAX_COLORS);
   localparam int CNTW  = $clog2(MAX_COLORS + 1);
   localparam int FW    = cri_pkg::POS_FW;
   localparam int PW    = FW + IDXW;
   localparam int EW    = cri_pkg::ENTRY_W;
   localparam int CW    = cri_pkg::CHAN_W;
   localparam int F     = FRACTION_BITS;
   localparam int AW    = F + CW + 2;
   localparam int HALF  = 1 << (F - 1);
   localparam int HALF_Q16 = 1 << (FW - 1);
   localparam int RST_N = (MAX_COLORS < cri_pkg::RESET_ENTRIES) ?
                          MAX_COLORS : cri_pkg::RESET_ENTRIES;
   localparam int XW    = 40;     // fraction staging width, covers the widest F

   localparam logic [1:0] MODE_NONE = 2'd0;
   localparam logic [1:0] MODE_GRAY = 2'd1;
   localparam logic [1:0] MODE_LERP = 2'd2;

   logic [EW-1:0]   mem [MAX_COLORS];

   logic [CNTW-1:0] count_ff, count_in;
   logic [RST_N-1:0] ovr_ff, ovr_in;
   logic [1:0]      mode_ff, mode_in;
   logic            status_ff, status_in;
   logic [CW-1:0]   gray_ff, gray_in;
   logic [PW-1:0]   p_ff, p_in;

   logic [EW-1:0]   left_q_ff, right_q_ff;
   logic            left_use_ff, right_use_ff;
   logic [EW-1:0]   left_rst_ff, right_rst_ff;

   logic [CW-1:0]   red_ff, green_ff, blue_ff, alpha_ff;
   logic            stat_out_ff;

   logic            full;
   logic            do_write;
   logic [IDXW-1:0] last_idx;
   logic            pos_neg, pos_ge_one;
   logic [FW:0]     tc;
   logic [FW+CW:0]  gray_sum;
   logic [IDXW-1:0] lidx, ridx;
   logic [XW-1:0]   frac_ext;
   logic [F-1:0]    frac;
   logic            left_use, right_use;
   logic [EW-1:0]   left_rst, right_rst;
   logic [EW-1:0]   left_word, right_word;
   logic [CW-1:0]   lane_val [4];

   // ---------------- accept stage ----------------
   assign full       = (count_ff == CNTW'(MAX_COLORS));
   assign do_write   = cmd.accept && (req_opcode == cri_pkg::OP_APPEND) && !full;
   assign last_idx   = IDXW'(count_ff - CNTW'(1));
   assign pos_neg    = req_position[cri_pkg::POS_W-1];
   assign pos_ge_one = !pos_neg && req_position[FW];

   // clamp to [0, 1.0] then scale by 255 with rounding
   always_comb begin
      if (pos_neg) begin
         tc = '0;
      end else if (pos_ge_one) begin
         tc = (FW+1)'(1) << FW;
      end else begin
         tc = {1'b0, req_position[FW-1:0]};
      end
      gray_sum = {tc, {CW{1'b0}}} - (FW+CW+1)'(tc) + (FW+CW+1)'(HALF_Q16);
      gray_in  = gray_sum[FW +: CW];
   end

   always_comb begin
      count_in  = count_ff;
      ovr_in    = ovr_ff;
      mode_in   = mode_ff;
      status_in = status_ff;
      p_in      = p_ff;
      if (cmd.accept) begin
         mode_in   = MODE_NONE;
         status_in = 1'b0;
         p_in      = '0;
         case (req_opcode)
            cri_pkg::OP_SAMPLE: begin
               if (count_ff == '0) begin
                  mode_in = MODE_GRAY;
               end else begin
                  mode_in = MODE_LERP;
                  // special cases pick one entry with a zero fraction
                  if (count_ff == CNTW'(1) || pos_neg) begin
                     p_in = '0;
                  end else if (pos_ge_one) begin
                     p_in = {last_idx, {FW{1'b0}}};
                  end else begin
                     p_in = PW'(req_position[FW-1:0]) * PW'(last_idx);
                  end
               end
            end
            cri_pkg::OP_APPEND: begin
               if (full) begin
                  status_in = 1'b1;
               end else begin
                  count_in = count_ff + CNTW'(1);
                  for (int k = 0; k < RST_N; k++) begin
                     if (count_ff == CNTW'(k)) ovr_in[k] = 1'b0;
                  end
               end
            end
            cri_pkg::OP_CLEAR: begin
               count_in = '0;
            end
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= CNTW'(RST_N);
         ovr_ff   <= '1;
      end else begin
         count_ff <= count_in;
         ovr_ff   <= ovr_in;
      end
   end

   always_ff @(posedge clock) begin
      mode_ff   <= mode_in;
      status_ff <= status_in;
      p_ff      <= p_in;
      if (cmd.accept) begin
         gray_ff <= gray_in;
      end
   end

   // ---------------- table read stage ----------------
   assign lidx     = p_ff[FW +: IDXW];
   // with a zero fraction the right entry does not count and may be past the last one
   assign ridx     = (lidx == IDXW'(MAX_COLORS - 1) || p_ff[FW-1:0] == '0) ?
                     lidx : lidx + IDXW'(1);
   assign frac_ext = {p_ff[FW-1:0], {(XW-FW){1'b0}}};
   assign frac     = frac_ext[XW-1 -: F];

   always_comb begin
      left_use  = 1'b0;
      right_use = 1'b0;
      left_rst  = '0;
      right_rst = '0;
      for (int k = 0; k < RST_N; k++) begin
         if (lidx == IDXW'(k) && ovr_ff[k]) begin
            left_use = 1'b1;
            left_rst = cri_pkg::reset_color(2'(k));
         end
         if (ridx == IDXW'(k) && ovr_ff[k]) begin
            right_use = 1'b1;
            right_rst = cri_pkg::reset_color(2'(k));
         end
      end
   end

   always_ff @(posedge clock) begin
      if (do_write) begin
         mem[count_ff[IDXW-1:0]] <= {req_alpha_in, req_blue_in, req_green_in, req_red_in};
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.read) begin
         left_q_ff  <= mem[lidx];
         right_q_ff <= mem[ridx];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.read) begin
         left_use_ff  <= left_use;
         right_use_ff <= right_use;
         left_rst_ff  <= left_rst;
         right_rst_ff <= right_rst;
      end
   end

   // ---------------- lerp stage ----------------
   assign left_word  = left_use_ff  ? left_rst_ff  : left_q_ff;
   assign right_word = right_use_ff ? right_rst_ff : right_q_ff;

   // l + (r - l) * f, rounded half up
   for (genvar k = 0; k < 4; k++) begin : g_lane
      logic [CW-1:0]        l_ch, r_ch;
      logic signed [CW:0]   diff;
      logic signed [AW-1:0] prod, acc;
      assign l_ch = left_word[CW*k +: CW];
      assign r_ch = right_word[CW*k +: CW];
      assign diff = $signed({1'b0, r_ch}) - $signed({1'b0, l_ch});
      assign prod = diff * $signed({1'b0, frac});
      assign acc  = $signed({2'b00, l_ch, {F{1'b0}}}) + prod + $signed(AW'(HALF));
      assign lane_val[k] = acc[F +: CW];
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         stat_out_ff <= status_ff;
         case (mode_ff)
            MODE_GRAY: begin
               red_ff   <= gray_ff;
               green_ff <= gray_ff;
               blue_ff  <= gray_ff;
               alpha_ff <= gray_ff;
            end
            MODE_LERP: begin
               red_ff   <= lane_val[0];
               green_ff <= lane_val[1];
               blue_ff  <= lane_val[2];
               alpha_ff <= lane_val[3];
            end
            default: begin
               red_ff   <= '0;
               green_ff <= '0;
               blue_ff  <= '0;
               alpha_ff <= '0;
            end
         endcase
      end
   end

   assign rsp_red_out   = red_ff;
   assign rsp_green_out = green_ff;
   assign rsp_blue_out  = blue_ff;
   assign rsp_alpha_out = alpha_ff;
   assign rsp_status    = stat_out_ff;

endmodule

// ----- rtl/color_ramp_interpolator.sv -----
// Color ramp interpolator top level: joins the controller and the datapath.
// Depends on cri_pkg, cri_ctrl and cri_datapath.
//
// Usage:
//  - Request channel (req_*): opcode 0 samples the ramp at the signed Q2.16
//    position, 1 appends the RGBA entry on req_*_in, 2 clears the table.
//  - Response channel (rsp_*): one transfer per request, in order. Samples
//    return the interpolated color; other opcodes return zero color, and
//    rsp_status is 1 when an append found the table full.
//  - Pipeline: the scale multiply is registered at the transfer edge, then
//    the table read, then the lerp into the result register; rsp_valid rises
//    when the result register is loaded.
//  - Flow: req_ready is high only while no request is in work. A held
//    result does not block the next transfer; that request waits in the
//    lerp stage until the result is taken.
//  - Receiver stall: the result register holds its value with rsp_valid high
//    until rsp_ready.
//  - Reset: synchronous, active high. The ramp comes up as red, white, blue
//    with three entries; no clearing pass is needed.
module color_ramp_interpolator #(
   parameter int MAX_COLORS    = cri_pkg::MAX_COLORS_DEF,
   parameter int FRACTION_BITS = cri_pkg::FRACTION_BITS_DEF
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_ready,
   input  logic [cri_pkg::OP_W-1:0]         req_opcode,
   input  logic signed [cri_pkg::POS_W-1:0] req_position,
   input  logic [cri_pkg::CHAN_W-1:0]       req_red_in,
   input  logic [cri_pkg::CHAN_W-1:0]       req_green_in,
   input  logic [cri_pkg::CHAN_W-1:0]       req_blue_in,
   input  logic [cri_pkg::CHAN_W-1:0]       req_alpha_in,
   output logic                             rsp_valid,
   input  logic                             rsp_ready,
   output logic [cri_pkg::CHAN_W-1:0]       rsp_red_out,
   output logic [cri_pkg::CHAN_W-1:0]       rsp_green_out,
   output logic [cri_pkg::CHAN_W-1:0]       rsp_blue_out,
   output logic [cri_pkg::CHAN_W-1:0]       rsp_alpha_out,
   output logic                             rsp_status
);

   cri_pkg::cmd_type cmd;

   cri_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .cmd       (cmd)
   );

   cri_datapath #(
      .MAX_COLORS    (MAX_COLORS),
      .FRACTION_BITS (FRACTION_BITS)
   ) u_datapath (
      .clock         (clock),
      .reset         (reset),
      .cmd           (cmd),
      .req_opcode    (req_opcode),
      .req_position  (req_position),
      .req_red_in    (req_red_in),
      .req_green_in  (req_green_in),
      .req_blue_in   (req_blue_in),
      .req_alpha_in  (req_alpha_in),
      .rsp_red_out   (rsp_red_out),
      .rsp_green_out (rsp_green_out),
      .rsp_blue_out  (rsp_blue_out),
      .rsp_alpha_out (rsp_alpha_out),
      .rsp_status    (rsp_status)
   );

endmodule

// ----- tb/cri_response_checker.sv -----
// Response checker for the color ramp interpolator: predicts each response from the
// request transfers, keeps its own ramp table, and compares every response transfer.
// Depends on cri_pkg.
module cri_response_checker (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   input  logic                             req_ready,
   input  logic [cri_pkg::OP_W-1:0]         req_opcode,
   input  logic signed [cri_pkg::POS_W-1:0] req_position,
   input  logic [cri_pkg::CHAN_W-1:0]       req_red_in,
   input  logic [cri_pkg::CHAN_W-1:0]       req_green_in,
   input  logic [cri_pkg::CHAN_W-1:0]       req_blue_in,
   input  logic [cri_pkg::CHAN_W-1:0]       req_alpha_in,
   input  logic                             rsp_valid,
   input  logic                             rsp_ready,
   input  logic [cri_pkg::CHAN_W-1:0]       rsp_red_out,
   input  logic [cri_pkg::CHAN_W-1:0]       rsp_green_out,
   input  logic [cri_pkg::CHAN_W-1:0]       rsp_blue_out,
   input  logic [cri_pkg::CHAN_W-1:0]       rsp_alpha_out,
   input  logic                             rsp_status,
   output int                               outstanding,
   output int                               fail_count
);
   timeunit 1ns;
   timeprecision 1ps;

   localparam int     RAMP_DEPTH = cri_pkg::MAX_COLORS_DEF;
   localparam int     FRAC       = cri_pkg::FRACTION_BITS_DEF;
   localparam int     EW         = cri_pkg::ENTRY_W;
   localparam longint POS_ONE    = longint'(1) << cri_pkg::POS_FW;

   // rgba packs like a ramp entry: red 7..0 up to alpha 31..24
   typedef struct packed {
      logic          status;
      logic [EW-1:0] rgba;
   } shade_type;

   logic [EW-1:0] ramp [RAMP_DEPTH];
   int            ramp_len;
   shade_type     expected_shades [$];
   int            error_count = 0;
   string         chan_names [4] = '{"red_out", "green_out", "blue_out", "alpha_out"};

   assign fail_count = error_count + outstanding;

   function automatic logic [EW-1:0] sample_ramp(
      input logic signed [cri_pkg::POS_W-1:0] t);
      longint        tv, tc, p, f, lv, rv, v;
      longint        one, half;
      int            idx;
      logic [EW-1:0] lo, hi, mix;
      tv   = t;
      one  = longint'(1) << FRAC;
      half = one >> 1;
      if (ramp_len == 0) begin
         // empty ramp: gray ramp of the clamped scalar
         tc = (tv < 0) ? 0 : ((tv > POS_ONE) ? POS_ONE : tv);
         v  = (tc * 255 + 32768) >> 16;
         return {4{v[7:0]}};
      end
      if (ramp_len == 1) return ramp[0];
      if (tv >= POS_ONE) return ramp[ramp_len - 1];
      if (tv < 0) return ramp[0];
      p   = tv * longint'(ramp_len - 1);
      idx = int'(p >> cri_pkg::POS_FW);
      f   = p & ((longint'(1) << cri_pkg::POS_FW) - 1);
      if (FRAC >= cri_pkg::POS_FW) f = f << (FRAC - cri_pkg::POS_FW);
      else f = f >> (cri_pkg::POS_FW - FRAC);
      lo = ramp[idx];
      hi = ramp[idx + 1];
      for (int k = 0; k < 4; k++) begin
         lv = lo[8*k +: 8];
         rv = hi[8*k +: 8];
         v  = (lv * (one - f) + rv * f + half) >> FRAC;
         mix[8*k +: 8] = v[7:0];
      end
      return mix;
   endfunction

   function automatic shade_type apply_request(input logic [cri_pkg::OP_W-1:0] op,
                                               input logic signed [cri_pkg::POS_W-1:0] pos,
                                               input logic [EW-1:0] entry);
      shade_type s;
      s = '0;
      case (op)
         cri_pkg::OP_SAMPLE: s.rgba = sample_ramp(pos);
         cri_pkg::OP_APPEND: begin
            if (ramp_len >= RAMP_DEPTH) begin
               s.status = 1'b1;
            end else begin
               ramp[ramp_len] = entry;
               ramp_len++;
            end
         end
         cri_pkg::OP_CLEAR:  ramp_len = 0;   // entries keep their bits
         default:   ;
      endcase
      return s;
   endfunction

   always @(posedge clock) begin : watch
      shade_type     want;
      logic [EW-1:0] got;
      if (reset) begin
         for (int i = 0; i < RAMP_DEPTH; i++) ramp[i] = '0;
         ramp[0]  = cri_pkg::COLOR_RED;
         ramp[1]  = cri_pkg::COLOR_WHITE;
         ramp[2]  = cri_pkg::COLOR_BLUE;
         ramp_len = cri_pkg::RESET_ENTRIES;
         expected_shades.delete();
      end else begin
         // retire first: a response never belongs to a request taken on the same edge
         if (rsp_valid && rsp_ready) begin
            if (expected_shades.size() == 0) begin
               $error("response transfer with no request waiting");
               error_count++;
            end else begin
               want = expected_shades.pop_front();
               got  = {rsp_alpha_out, rsp_blue_out, rsp_green_out, rsp_red_out};
               for (int k = 0; k < 4; k++) begin
                  if (got[8*k +: 8] !== want.rgba[8*k +: 8]) begin
                     $error("%s: expected %0d, actual %0d", chan_names[k],
                            want.rgba[8*k +: 8], got[8*k +: 8]);
                     error_count++;
                  end
               end
               if (rsp_status !== want.status) begin
                  $error("status: expected %0d, actual %0d", want.status, rsp_status);
                  error_count++;
               end
            end
         end
         if (req_valid && req_ready) begin
            want = apply_request(req_opcode, req_position,
                                 {req_alpha_in, req_blue_in, req_green_in, req_red_in});
            expected_shades = {expected_shades, want};
         end
      end
      outstanding = expected_shades.size();
   end

endmodule

// ----- tb/tb.sv -----
// Top of the color ramp interpolator testbench: clock, reset, request stimulus,
// response back-pressure and the verdict.
// Depends on cri_pkg, color_ramp_interpolator and cri_response_checker.
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam logic [cri_pkg::OP_W-1:0] OP_NOOP     = 2'd3;
   localparam int                       ITEMS_TOTAL = 1575;

   logic                             clock        = 1'b0;
   logic                             reset        = 1'b1;
   logic                             req_valid    = 1'b0;
   logic                             req_ready;
   logic [cri_pkg::OP_W-1:0]         req_opcode   = '0;
   logic signed [cri_pkg::POS_W-1:0] req_position = '0;
   logic [cri_pkg::CHAN_W-1:0]       req_red_in   = '0;
   logic [cri_pkg::CHAN_W-1:0]       req_green_in = '0;
   logic [cri_pkg::CHAN_W-1:0]       req_blue_in  = '0;
   logic [cri_pkg::CHAN_W-1:0]       req_alpha_in = '0;
   logic                             rsp_valid;
   logic                             rsp_ready    = 1'b0;
   logic [cri_pkg::CHAN_W-1:0]       rsp_red_out;
   logic [cri_pkg::CHAN_W-1:0]       rsp_green_out;
   logic [cri_pkg::CHAN_W-1:0]       rsp_blue_out;
   logic [cri_pkg::CHAN_W-1:0]       rsp_alpha_out;
   logic                             rsp_status;
   int                               outstanding;
   int                               fail_count;

   int items_sent = 0;
   int burst_left = 0;
   int ready_left = 0;
   int ready_mode = 0;
   int ready_tick = 0;

   always #5 clock = ~clock;

   color_ramp_interpolator dut (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_opcode    (req_opcode),
      .req_position  (req_position),
      .req_red_in    (req_red_in),
      .req_green_in  (req_green_in),
      .req_blue_in   (req_blue_in),
      .req_alpha_in  (req_alpha_in),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_red_out   (rsp_red_out),
      .rsp_green_out (rsp_green_out),
      .rsp_blue_out  (rsp_blue_out),
      .rsp_alpha_out (rsp_alpha_out),
      .rsp_status    (rsp_status)
   );

   cri_response_checker resp_check (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_opcode    (req_opcode),
      .req_position  (req_position),
      .req_red_in    (req_red_in),
      .req_green_in  (req_green_in),
      .req_blue_in   (req_blue_in),
      .req_alpha_in  (req_alpha_in),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_red_out   (rsp_red_out),
      .rsp_green_out (rsp_green_out),
      .rsp_blue_out  (rsp_blue_out),
      .rsp_alpha_out (rsp_alpha_out),
      .rsp_status    (rsp_status),
      .outstanding   (outstanding),
      .fail_count    (fail_count)
   );

   // receiver back-pressure: phases of always-ready, coin flips, a fixed
   // one-in-four pattern and long stalls
   always @(negedge clock) begin
      if (ready_left == 0) begin
         ready_mode = $urandom_range(0, 3);
         ready_left = $urandom_range(5, 60);
      end
      ready_left--;
      ready_tick++;
      case (ready_mode)
         0:       rsp_ready <= 1'b1;
         1:       rsp_ready <= $urandom_range(0, 1);
         2:       rsp_ready <= (ready_tick % 4 == 0);
         default: rsp_ready <= ($urandom_range(0, 9) == 0);
      endcase
   end

   function automatic logic signed [cri_pkg::POS_W-1:0] pick_position();
      case ($urandom_range(0, 9))
         0, 1, 2, 3, 4, 5: return cri_pkg::POS_W'($urandom_range(0, 65535));
         6:                return cri_pkg::POS_W'($urandom_range(65536, 131071));
         7:                return cri_pkg::POS_W'($urandom_range(131072, 262143));   // negative
         8: begin
            case ($urandom_range(0, 5))
               0:       return 18'sd0;
               1:       return 18'sd65535;
               2:       return 18'sd65536;
               3:       return -18'sd1;
               4:       return 18'sd131071;
               default: return -18'sd131072;
            endcase
         end
         default:          return cri_pkg::POS_W'($urandom);
      endcase
   endfunction

   function automatic logic [cri_pkg::CHAN_W-1:0] pick_channel();
      case ($urandom_range(0, 7))
         0:       return 8'h00;
         1:       return 8'hFF;
         default: return cri_pkg::CHAN_W'($urandom_range(0, 255));
      endcase
   endfunction

   // one request transfer, preceded by a sender gap when a burst runs out
   task automatic transfer_request(input logic [cri_pkg::OP_W-1:0] op,
                                   input logic signed [cri_pkg::POS_W-1:0] pos,
                                   input logic [cri_pkg::CHAN_W-1:0] r, g, b, a);
      int gap;
      if (burst_left == 0) begin
         case ($urandom_range(0, 9))
            0, 1, 2, 3: gap = 0;
            9:          gap = $urandom_range(6, 20);
            default:    gap = $urandom_range(1, 5);
         endcase
         repeat (gap) @(negedge clock) req_valid <= 1'b0;
         burst_left = $urandom_range(1, 32);
      end
      burst_left--;
      @(negedge clock);
      req_valid    <= 1'b1;
      req_opcode   <= op;
      req_position <= pos;
      req_red_in   <= r;
      req_green_in <= g;
      req_blue_in  <= b;
      req_alpha_in <= a;
      do @(posedge clock); while (!req_ready);
      items_sent++;
   endtask

   task automatic sample_at(input logic signed [cri_pkg::POS_W-1:0] pos);
      transfer_request(cri_pkg::OP_SAMPLE, pos, pick_channel(), pick_channel(),
                       pick_channel(), pick_channel());
   endtask

   task automatic append_color(input logic [cri_pkg::CHAN_W-1:0] r, g, b, a);
      transfer_request(cri_pkg::OP_APPEND, pick_position(), r, g, b, a);
   endtask

   task automatic clear_ramp();
      transfer_request(cri_pkg::OP_CLEAR, pick_position(), pick_channel(), pick_channel(),
                       pick_channel(), pick_channel());
   endtask

   // hold the sender off until every response is back
   task automatic drain();
      @(negedge clock) req_valid <= 1'b0;
      while (outstanding != 0) @(negedge clock);
   endtask

   initial begin
      #5_000_000;
      $display("color_ramp_interpolator: mismatch");
      $finish;
   end

   initial begin : stimulus
      int c;
      int k;
      repeat (9) @(negedge clock);
      reset <= 1'b0;

      // reset ramp: red, white, blue
      sample_at(18'sd0);
      sample_at(18'sd16384);
      sample_at(18'sd65535);
      sample_at(18'sd65536);
      sample_at(-18'sd131072);
      transfer_request(OP_NOOP, 18'sd131071, 8'hFF, 8'hFF, 8'hFF, 8'hFF);
      // fill the table, then one append past full
      for (int i = 0; i < cri_pkg::MAX_COLORS_DEF - cri_pkg::RESET_ENTRIES; i++) begin
         if (i % 2 == 0) append_color(8'h00, 8'hFF, 8'h00, 8'hFF);
         else append_color(8'hFF, 8'h00, 8'hFF, 8'h00);
      end
      append_color(8'h5A, 8'hA5, 8'h3C, 8'hC3);
      sample_at(18'sd65535);
      // empty table gives gray
      clear_ramp();
      sample_at(18'sd32768);
      sample_at(18'sd131071);
      // single entry
      append_color(8'h12, 8'h34, 8'h56, 8'h78);
      sample_at(-18'sd1);

      while (items_sent < ITEMS_TOTAL) begin
         if (items_sent >= 800 && items_sent < 805) drain();
         else if ($urandom_range(0, 299) == 0) drain();
         c = $urandom_range(0, 99);
         if (c < 4) begin
            clear_ramp();
            k = $urandom_range(0, cri_pkg::MAX_COLORS_DEF + 2);
            repeat (k) append_color(pick_channel(), pick_channel(), pick_channel(),
                                    pick_channel());
         end else if (c < 8) begin
            transfer_request(OP_NOOP, pick_position(), pick_channel(), pick_channel(),
                             pick_channel(), pick_channel());
         end else if (c < 22) begin
            append_color(pick_channel(), pick_channel(), pick_channel(), pick_channel());
         end else begin
            sample_at(pick_position());
         end
      end

      drain();
      repeat (20) @(negedge clock);
      if (fail_count == 0) begin
         $display("color_ramp_interpolator: match");
      end else begin
         $display("color_ramp_interpolator: mismatch");
      end
      $finish;
   end

endmodule
